### hw/rtl/lsc_pkg.sv
// ----------------------------------------------------------------------------
// LED strip layer color package
// Shared constants, color tables and inter-module types of the frame
// color generator.
// ----------------------------------------------------------------------------
package lsc_pkg;

    // Strip geometry.
    localparam int PIXELS = 32;
    localparam int CNT_W  = 6;
    localparam int IDX_W  = 5;

    // Hue arithmetic.
    localparam int HUE_W     = 9;
    localparam int HUE_FULL  = 360;
    localparam int HUE_STEP  = HUE_FULL / PIXELS;
    localparam int HUE_FRAC  = HUE_FULL % PIXELS;

    // Swirl divider: dividend is uptime times 360, padded to an even width.
    localparam int DVD_W               = 42;
    localparam int DIV_STEPS_PER_CYCLE = 2;
    localparam int DIV_CYCLES          = DVD_W / DIV_STEPS_PER_CYCLE;
    localparam int DIV_CNT_W           = 5;

    // Field widths of the streams and the register port.
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int BRIGHT_W   = 7;
    localparam int PERIOD_W   = 16;

    // Register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD     = 1'd1;

    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd20;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd3000;

    // Solid layer hue table and saturation levels (percent scaled to 0..255).
    localparam logic [HUE_W-1:0] HUE_TAB [4] = '{9'd182, 9'd120, 9'd0, 9'd30};
    localparam logic [7:0] SAT_LVL_TAB [4] = '{
        8'(73 * 255 / 100), 8'(100 * 255 / 100), 8'(100 * 255 / 100), 8'(100 * 255 / 100)
    };
    localparam logic [7:0] SWIRL_SAT_LVL = 8'(73 * 255 / 100);

    // Reciprocal multipliers for division by constants.
    localparam logic [12:0] RCP_100   = 13'd5243;     // x / 100  = (x * K) >> 19
    localparam logic [10:0] RCP_60    = 11'd1093;     // h / 60   = (h * K) >> 16
    localparam logic [21:0] RCP_F     = 22'd2184550;  // m*1000/60 = (m * K) >> 17
    localparam logic [18:0] RCP_1000  = 19'd268436;   // x / 1000 = (x * K) >> 28
    localparam logic [17:0] RCP_255   = 18'd131587;   // x / 255  = (x * K) >> 25

    // Hue sector codes.
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;

    // Frame job from the divider to the pixel sequencer.
    typedef struct packed {
        logic             valid;
        logic [HUE_W-1:0] base;
        logic             solid;
        logic [1:0]       sel;
        logic             on;
    } job_t;

    // One pixel entering the color pipeline.
    typedef struct packed {
        logic             valid;
        logic [HUE_W-1:0] hue;
        logic [7:0]       sat;
        logic             blank;
        logic [IDX_W-1:0] idx;
        logic             last;
    } pix_t;

endpackage

### hw/rtl/lsc_hue_div.sv
// ----------------------------------------------------------------------------
// Swirl base hue divider
// Computes (uptime * 360 / period) mod 360 with a restoring divider that
// retires two quotient bits per cycle, keeping the quotient reduced mod 360.
// ----------------------------------------------------------------------------
module lsc_hue_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lsc_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [lsc_pkg::PERIOD_W-1:0]  period,
    input  logic                          take,
    output lsc_pkg::job_t                 job
);

    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic [lsc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [lsc_pkg::DVD_W-1:0]     dvd_reg, dvd_next;
    logic [lsc_pkg::PERIOD_W-1:0]  rem_reg, rem_next;
    logic [lsc_pkg::PERIOD_W-1:0]  per_reg, per_next;
    logic [lsc_pkg::HUE_W-1:0]     quo_reg, quo_next;
    logic                          solid_reg, solid_next;
    logic [1:0]                    sel_reg, sel_next;
    logic                          on_reg, on_next;

    logic                          accept;
    logic [lsc_pkg::DVD_W-1:0]     dvd_step;
    logic [lsc_pkg::PERIOD_W-1:0]  rem_step;
    logic [lsc_pkg::HUE_W-1:0]     quo_step;

    assign s_tready = !busy_reg || take;
    assign accept   = s_tvalid && s_tready;

    // Two restoring steps; the quotient only matters modulo 360.
    always_comb begin
        logic [lsc_pkg::PERIOD_W:0] r_sh;
        logic [lsc_pkg::HUE_W:0]    q_sh;
        logic                       qbit;
        dvd_step = dvd_reg;
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int k = 0; k < lsc_pkg::DIV_STEPS_PER_CYCLE; k++) begin
            r_sh     = {rem_step, dvd_step[lsc_pkg::DVD_W-1]};
            dvd_step = {dvd_step[lsc_pkg::DVD_W-2:0], 1'b0};
            if (r_sh >= {1'b0, per_reg}) begin
                r_sh = r_sh - {1'b0, per_reg};
                qbit = 1'b1;
            end else begin
                qbit = 1'b0;
            end
            rem_step = r_sh[lsc_pkg::PERIOD_W-1:0];
            q_sh     = {quo_step, qbit};
            if (q_sh >= 10'(lsc_pkg::HUE_FULL)) begin
                q_sh = q_sh - 10'(lsc_pkg::HUE_FULL);
            end
            quo_step = q_sh[lsc_pkg::HUE_W-1:0];
        end
    end

    always_comb begin
        busy_next  = busy_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        per_next   = per_reg;
        quo_next   = quo_reg;
        solid_next = solid_reg;
        sel_next   = sel_reg;
        on_next    = on_reg;
        if (take) begin
            busy_next = 1'b0;
            fin_next  = 1'b0;
        end
        if (accept) begin
            busy_next  = 1'b1;
            fin_next   = 1'b0;
            cnt_next   = '0;
            dvd_next   = lsc_pkg::DVD_W'(s_tdata[31:0])
                         * lsc_pkg::DVD_W'(lsc_pkg::HUE_FULL);
            rem_next   = '0;
            quo_next   = '0;
            per_next   = (period == '0) ? lsc_pkg::PERIOD_W'(1) : period;
            solid_next = (s_tdata[39:32] != 8'd0);
            sel_next   = s_tdata[33:32];
            on_next    = s_tdata[40] && s_tdata[41];
        end else if (busy_reg && !fin_reg) begin
            dvd_next = dvd_step;
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lsc_pkg::DIV_CNT_W'(lsc_pkg::DIV_CYCLES - 1)) begin
                fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
        end
        cnt_reg   <= cnt_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        per_reg   <= per_next;
        quo_reg   <= quo_next;
        solid_reg <= solid_next;
        sel_reg   <= sel_next;
        on_reg    <= on_next;
    end

    assign job.valid = fin_reg;
    assign job.base  = quo_reg;
    assign job.solid = solid_reg;
    assign job.sel   = sel_reg;
    assign job.on    = on_reg;

endmodule

### hw/rtl/lsc_pix_seq.sv
// ----------------------------------------------------------------------------
// Pixel sequencer
// Walks the strip one pixel per cycle while en is high for the current frame and hands each
// pixel's hue and saturation to the color pipeline.
// ----------------------------------------------------------------------------
module lsc_pix_seq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  lsc_pkg::job_t job,
    output logic          take,
    output lsc_pkg::pix_t pix
);

    logic                      fv_reg, fv_next;
    logic [lsc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [lsc_pkg::HUE_W-1:0] oq_reg, oq_next;
    logic [lsc_pkg::CNT_W-1:0] or_reg, or_next;
    logic [lsc_pkg::HUE_W-1:0] base_reg, base_next;
    logic                      solid_reg, solid_next;
    logic [1:0]                sel_reg, sel_next;
    logic                      on_reg, on_next;
    lsc_pkg::pix_t             pix_reg, pix_next;

    logic                      last_pix;
    logic [lsc_pkg::HUE_W:0]   hsum;
    logic [lsc_pkg::HUE_W-1:0] swirl_hue;
    logic [lsc_pkg::CNT_W:0]   frac_sum;

    assign last_pix = fv_reg && (cnt_reg == lsc_pkg::CNT_W'(lsc_pkg::PIXELS - 1));
    assign take     = job.valid && en && (!fv_reg || last_pix);

    always_comb begin
        hsum = {1'b0, base_reg} + {1'b0, oq_reg};
        if (hsum >= 10'(lsc_pkg::HUE_FULL)) begin
            hsum = hsum - 10'(lsc_pkg::HUE_FULL);
        end
        swirl_hue = hsum[lsc_pkg::HUE_W-1:0];
    end

    // The hue offset i*360/PIXELS is kept as a quotient and a remainder.
    assign frac_sum = {1'b0, or_reg} + (lsc_pkg::CNT_W + 1)'(lsc_pkg::HUE_FRAC);

    always_comb begin
        fv_next    = fv_reg;
        cnt_next   = cnt_reg;
        oq_next    = oq_reg;
        or_next    = or_reg;
        base_next  = base_reg;
        solid_next = solid_reg;
        sel_next   = sel_reg;
        on_next    = on_reg;
        pix_next   = pix_reg;
        if (en) begin
            pix_next.valid = fv_reg;
            pix_next.hue   = solid_reg ? lsc_pkg::HUE_TAB[sel_reg] : swirl_hue;
            pix_next.sat   = solid_reg ? lsc_pkg::SAT_LVL_TAB[sel_reg] : lsc_pkg::SWIRL_SAT_LVL;
            pix_next.blank = !on_reg;
            pix_next.idx   = cnt_reg[lsc_pkg::IDX_W-1:0];
            pix_next.last  = last_pix;
            if (!fv_reg || last_pix) begin
                fv_next = job.valid;
                if (job.valid) begin
                    cnt_next   = '0;
                    oq_next    = '0;
                    or_next    = '0;
                    base_next  = job.base;
                    solid_next = job.solid;
                    sel_next   = job.sel;
                    on_next    = job.on;
                end
            end else begin
                cnt_next = cnt_reg + 1'b1;
                if (frac_sum >= (lsc_pkg::CNT_W + 1)'(lsc_pkg::PIXELS)) begin
                    or_next = lsc_pkg::CNT_W'(frac_sum - (lsc_pkg::CNT_W + 1)'(lsc_pkg::PIXELS));
                    oq_next = oq_reg + lsc_pkg::HUE_W'(lsc_pkg::HUE_STEP + 1);
                end else begin
                    or_next = frac_sum[lsc_pkg::CNT_W-1:0];
                    oq_next = oq_reg + lsc_pkg::HUE_W'(lsc_pkg::HUE_STEP);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg        <= 1'b0;
            pix_reg.valid <= 1'b0;
        end else begin
            fv_reg        <= fv_next;
            pix_reg.valid <= pix_next.valid;
        end
        cnt_reg       <= cnt_next;
        oq_reg        <= oq_next;
        or_reg        <= or_next;
        base_reg      <= base_next;
        solid_reg     <= solid_next;
        sel_reg       <= sel_next;
        on_reg        <= on_next;
        pix_reg.hue   <= pix_next.hue;
        pix_reg.sat   <= pix_next.sat;
        pix_reg.blank <= pix_next.blank;
        pix_reg.idx   <= pix_next.idx;
        pix_reg.last  <= pix_next.last;
    end

    assign pix = pix_reg;

endmodule

### hw/rtl/lsc_hsv.sv
// ----------------------------------------------------------------------------
// HSV to RGB pipeline
// Integer HSV-to-RGB conversion in six register stages plus the output
// register; every stage advances together when the output can move.
// ----------------------------------------------------------------------------
module lsc_hsv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lsc_pkg::pix_t                 pix,
    input  logic [lsc_pkg::BRIGHT_W-1:0]  brightness,
    output logic                          en,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsc_pkg::M_DATA_W-1:0]  m_tdata,   // pixel_index, red, green, blue, zero pad
    output logic                          m_tlast
);

    // Value level, refreshed every cycle from the brightness register.
    logic [14:0] bw_reg;
    logic [7:0]  vv_reg;
    logic [27:0] vv_prod;
    logic [8:0]  vv_full;

    // Per-stage item tags.
    logic [6:1]               v_reg;
    logic                     blank_reg [6:1];
    logic [lsc_pkg::IDX_W-1:0] idx_reg [6:1];
    logic                     last_reg [6:1];
    logic [2:0]               hi_reg [6:1];

    // Stage payloads.
    logic [lsc_pkg::HUE_W-1:0] h1_reg;
    logic [7:0]  sat1_reg, sat2_reg;
    logic [9:0]  f2_reg;
    logic [17:0] sf3_reg, st3_reg;
    logic [7:0]  yp3_reg, yp4_reg, yq4_reg, yt4_reg;
    logic [15:0] xp5_reg, xq5_reg, xt5_reg;
    logic [7:0]  p6_reg, q6_reg, t6_reg;

    logic        out_valid_reg;
    logic [lsc_pkg::M_DATA_W-1:0] out_data_reg;
    logic        out_last_reg;

    logic [19:0] hmul;
    logic [8:0]  m_full;
    logic [5:0]  m_val;
    logic [27:0] fmul;
    logic [36:0] qa_prod, ta_prod;
    logic [33:0] pp_prod, qp_prod, tp_prod;
    logic [7:0]  r_sel, g_sel, b_sel;

    assign en = !out_valid_reg || m_tready;

    assign vv_prod = bw_reg * lsc_pkg::RCP_100;
    assign vv_full = vv_prod[27:19];

    always_ff @(posedge aclk) begin
        bw_reg <= brightness * 8'd255;
        vv_reg <= (vv_full > 9'd255) ? 8'd255 : vv_full[7:0];
    end

    // Sector: h / 60 for h below 360.
    assign hmul   = pix.hue * lsc_pkg::RCP_60;
    // Fraction within the sector in thousandths, 0..983.
    assign m_full = h1_reg - ({6'd0, hi_reg[1]} * 9'd60);
    assign m_val  = m_full[5:0];
    assign fmul   = m_val * lsc_pkg::RCP_F;
    assign qa_prod = sf3_reg * lsc_pkg::RCP_1000;
    assign ta_prod = st3_reg * lsc_pkg::RCP_1000;
    assign pp_prod = xp5_reg * lsc_pkg::RCP_255;
    assign qp_prod = xq5_reg * lsc_pkg::RCP_255;
    assign tp_prod = xt5_reg * lsc_pkg::RCP_255;

    always_comb begin
        case (hi_reg[6])
            lsc_pkg::SEC_0: begin
                r_sel = vv_reg; g_sel = t6_reg; b_sel = p6_reg;
            end
            lsc_pkg::SEC_1: begin
                r_sel = q6_reg; g_sel = vv_reg; b_sel = p6_reg;
            end
            lsc_pkg::SEC_2: begin
                r_sel = p6_reg; g_sel = vv_reg; b_sel = t6_reg;
            end
            lsc_pkg::SEC_3: begin
                r_sel = p6_reg; g_sel = q6_reg; b_sel = vv_reg;
            end
            lsc_pkg::SEC_4: begin
                r_sel = t6_reg; g_sel = p6_reg; b_sel = vv_reg;
            end
            default: begin
                r_sel = vv_reg; g_sel = p6_reg; b_sel = q6_reg;
            end
        endcase
        if (blank_reg[6]) begin
            r_sel = 8'd0;
            g_sel = 8'd0;
            b_sel = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg         <= {v_reg[5:1], pix.valid};
            out_valid_reg <= v_reg[6];
        end
        if (en) begin
            blank_reg[1] <= pix.blank;
            idx_reg[1]   <= pix.idx;
            last_reg[1]  <= pix.last;
            hi_reg[1]    <= hmul[18:16];
            for (int s = 2; s <= 6; s++) begin
                blank_reg[s] <= blank_reg[s-1];
                idx_reg[s]   <= idx_reg[s-1];
                last_reg[s]  <= last_reg[s-1];
                hi_reg[s]    <= hi_reg[s-1];
            end
            h1_reg   <= pix.hue;
            sat1_reg <= pix.sat;
            // Stage 2
            f2_reg   <= fmul[26:17];
            sat2_reg <= sat1_reg;
            // Stage 3
            sf3_reg  <= sat2_reg * f2_reg;
            st3_reg  <= sat2_reg * (10'd1000 - f2_reg);
            yp3_reg  <= 8'd255 - sat2_reg;
            // Stage 4
            yq4_reg  <= 8'd255 - qa_prod[35:28];
            yt4_reg  <= 8'd255 - ta_prod[35:28];
            yp4_reg  <= yp3_reg;
            // Stage 5
            xp5_reg  <= vv_reg * yp4_reg;
            xq5_reg  <= vv_reg * yq4_reg;
            xt5_reg  <= vv_reg * yt4_reg;
            // Stage 6
            p6_reg   <= pp_prod[32:25];
            q6_reg   <= qp_prod[32:25];
            t6_reg   <= tp_prod[32:25];
            // Output register
            out_data_reg <= {3'b000, b_sel, g_sel, r_sel, idx_reg[6]};
            out_last_reg <= last_reg[6];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### hw/rtl/led_strip_layer_color_frame.sv
// Throughput: one pixel per cycle unless m_tready stalls the output; the strip walk sets
// this, while the base hue divider works on the next item in its shadow.
// Reset: aresetn is synchronous and active low; it empties the pipeline and restores
// the brightness to 20 percent and the swirl period to 3000 ms.
// ----------------------------------------------------------------------------
// LED strip layer color frame generator
// Turns each frame tick into one RGB item per strip pixel: a hue swirl on
// layer 0, a solid table color on other layers, black when blanked.
// ----------------------------------------------------------------------------
module led_strip_layer_color_frame (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lsc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // uptime_ms, layer, enabled, active, zero pad
    input  logic [lsc_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_index, red, green, blue, zero pad
    output logic [lsc_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                            m_tlast
);

    logic [lsc_pkg::BRIGHT_W-1:0] bright_reg;
    logic [lsc_pkg::PERIOD_W-1:0] period_reg;

    lsc_pkg::job_t job;
    lsc_pkg::pix_t pix;
    logic          take;
    logic          en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= lsc_pkg::BRIGHT_RESET;
            period_reg <= lsc_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lsc_pkg::REG_BRIGHTNESS: bright_reg <= cfg_wdata[lsc_pkg::BRIGHT_W-1:0];
                lsc_pkg::REG_PERIOD:     period_reg <= cfg_wdata[lsc_pkg::PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lsc_hue_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .period   (period_reg),
        .take     (take),
        .job      (job)
    );

    lsc_pix_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .job     (job),
        .take    (take),
        .pix     (pix)
    );

    lsc_hsv u_hsv (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix        (pix),
        .brightness (bright_reg),
        .en         (en),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// Frame color generator testbench
// Sends frame ticks to the strip color generator and checks every pixel
// item against a local HSV swirl and solid color predictor. A directed table
// covers blanking, register extremes and the color table; random phases with
// new register settings and random idling on both streams follow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PLAN_LEN     = 26;
    localparam int NUM_PHASES   = 5;
    localparam int PHASE_ITEMS  = 90;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYC   = 64;
    localparam int SWIRL_SAT    = 73;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic [31:0] uptime;
        logic [7:0]  layer;
        logic        enabled;
        logic        active;
    } tick_t;

    typedef struct packed {
        logic [lsc_pkg::IDX_W-1:0] idx;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic                      last;
    } pixel_t;

    // A write row uses addr and the low bits of value; a tick row uses value and the fields after it.
    // When typed is set, every pixel of the frame must carry rgb as {r, g, b}.
    typedef struct packed {
        row_kind_t                       kind;
        logic [lsc_pkg::CFG_ADDR_W-1:0]  addr;
        logic [31:0]                     value;
        logic [7:0]                      layer;
        logic                            en;
        logic                            act;
        logic                            typed;
        logic [23:0]                     rgb;
    } plan_row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [lsc_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [lsc_pkg::S_DATA_W-1:0]    s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [lsc_pkg::M_DATA_W-1:0]    m_tdata;
    logic                            m_tlast;

    // Register copies for the predictor.
    logic [6:0]   bright_pct = 7'd20;
    logic [15:0]  period_ms  = 16'd3000;

    int unsigned solid_hue [4] = '{182, 120, 0, 30};
    int unsigned solid_sat [4] = '{73, 100, 100, 100};

    pixel_t       pixels_due [$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           stall_left = 0;
    logic         calm = 1'b0;

    plan_row_t plan [PLAN_LEN] = '{
        // Reset settings: swirl, then the three ways to blank the strip.
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'h0000_0000, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'h1234_5678, 8'd0, 1'b0, 1'b1, 1'b1, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b0, 1'b1, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'h0000_0000, 8'd255, 1'b0, 1'b0, 1'b1, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd1000, 8'd1, 1'b1, 1'b1, 1'b0, 24'h000000},
        // Layer four wraps onto the first table entry.
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd2000, 8'd4, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd2999, 8'd3, 1'b1, 1'b1, 1'b0, 24'h000000},
        // Upper data bits must be dropped by the 7-bit brightness register.
        '{ROW_WRITE, lsc_pkg::REG_BRIGHTNESS, 32'h0000_FF64, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'h5555_5555, 8'd2, 1'b1, 1'b1, 1'b1, 24'hFF0000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'hAAAA_AAAA, 8'd1, 1'b1, 1'b1, 1'b1, 24'h00FF00},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000},
        // Brightness above 100 percent saturates the value level.
        '{ROW_WRITE, lsc_pkg::REG_BRIGHTNESS, 32'h0000_007F, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'h0000_0000, 8'd170, 1'b1, 1'b1, 1'b1, 24'hFF0000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd12345, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_WRITE, lsc_pkg::REG_BRIGHTNESS, 32'h0000_0000, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd777, 8'd0, 1'b1, 1'b1, 1'b1, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd777, 8'd85, 1'b1, 1'b1, 1'b1, 24'h000000},
        // A zero period behaves as one millisecond.
        '{ROW_WRITE, lsc_pkg::REG_PERIOD, 32'h0000_0000, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_WRITE, lsc_pkg::REG_BRIGHTNESS, 32'd55, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd1, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_WRITE, lsc_pkg::REG_PERIOD, 32'h0000_FFFF, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'hFFFF_FFFF, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd65534, 8'd128, 1'b1, 1'b1, 1'b0, 24'h000000},
        '{ROW_WRITE, lsc_pkg::REG_PERIOD, 32'h0000_0001, 8'd0, 1'b0, 1'b0, 1'b0, 24'h000000},
        '{ROW_TICK, lsc_pkg::REG_BRIGHTNESS, 32'd7, 8'd0, 1'b1, 1'b1, 1'b0, 24'h000000}
    };

    led_strip_layer_color_frame dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Integer HSV to RGB with saturation and value given in percent.
    function automatic pixel_t hsv_color(input int unsigned hue, input int unsigned sat_pct,
                                         input int unsigned val_pct);
        int unsigned vv, sat, sector, frac, p, q, rise;
        pixel_t c;
        vv = val_pct * 255 / 100;
        sat = sat_pct * 255 / 100;
        if (vv > 255) vv = 255;
        if (sat > 255) sat = 255;
        c = '0;
        if (sat == 0) begin
            c.red = vv[7:0];
            c.green = vv[7:0];
            c.blue = vv[7:0];
            return c;
        end
        sector = (hue / 60) % 6;
        frac = (hue % 60) * 1000 / 60;
        p = vv * (255 - sat) / 255;
        q = vv * (255 - (sat * frac) / 1000) / 255;
        rise = vv * (255 - (sat * (1000 - frac)) / 1000) / 255;
        case (sector[2:0])
            lsc_pkg::SEC_0: begin c.red = vv[7:0]; c.green = rise[7:0]; c.blue = p[7:0]; end
            lsc_pkg::SEC_1: begin c.red = q[7:0]; c.green = vv[7:0]; c.blue = p[7:0]; end
            lsc_pkg::SEC_2: begin c.red = p[7:0]; c.green = vv[7:0]; c.blue = rise[7:0]; end
            lsc_pkg::SEC_3: begin c.red = p[7:0]; c.green = q[7:0]; c.blue = vv[7:0]; end
            lsc_pkg::SEC_4: begin c.red = rise[7:0]; c.green = p[7:0]; c.blue = vv[7:0]; end
            default: begin c.red = vv[7:0]; c.green = p[7:0]; c.blue = q[7:0]; end
        endcase
        return c;
    endfunction

    function automatic void queue_pixel(input int i, input pixel_t c);
        c.idx = i[lsc_pkg::IDX_W-1:0];
        c.last = (i == lsc_pkg::PIXELS - 1);
        pixels_due.push_back(c);
    endfunction

    // Frame with the same color on every pixel.
    function automatic void queue_flat(input logic [23:0] rgb);
        pixel_t c;
        c = '0;
        c.red = rgb[23:16];
        c.green = rgb[15:8];
        c.blue = rgb[7:0];
        for (int i = 0; i < lsc_pkg::PIXELS; i++) queue_pixel(i, c);
    endfunction

    function automatic void queue_frame(input tick_t t);
        logic [63:0] scaled;
        int unsigned per, base, hue;
        pixel_t solid, c;
        logic on;
        on = t.enabled && t.active;
        per = (period_ms == 16'd0) ? 1 : period_ms;
        scaled = {32'd0, t.uptime} * 64'd360;
        base = int'((scaled / 64'(per)) % 64'd360);
        solid = hsv_color(solid_hue[t.layer[1:0]], solid_sat[t.layer[1:0]], bright_pct);
        for (int i = 0; i < lsc_pkg::PIXELS; i++) begin
            c = '0;
            if (on) begin
                if (t.layer == 8'd0) begin
                    hue = (base + i * 360 / lsc_pkg::PIXELS) % 360;
                    c = hsv_color(hue, SWIRL_SAT, bright_pct);
                end else begin
                    c = solid;
                end
            end
            queue_pixel(i, c);
        end
    endfunction

    task automatic note_mismatch(input pixel_t want, input pixel_t got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: want idx %0d rgb %h %h %h last %b, got idx %0d rgb %h %h %h last %b",
                     want.idx, want.red, want.green, want.blue, want.last,
                     got.idx, got.red, got.green, got.blue, got.last);
    endtask

    // Registers change only with nothing in flight, so the sender waits for the
    // last pixel first.
    task automatic write_reg(input logic [lsc_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [15:0] value);
        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == lsc_pkg::REG_BRIGHTNESS) bright_pct = value[6:0];
        else period_ms = value;
        @(posedge aclk);
    endtask

    task automatic send_tick(input tick_t t, input logic typed, input logic [23:0] rgb);
        s_tdata <= {6'd0, t.active, t.enabled, t.layer, t.uptime};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (typed) queue_flat(rgb);
        else queue_frame(t);
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    function automatic tick_t random_tick();
        tick_t t;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        t.uptime = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000) : $urandom;
        t.enabled = 1'b1;
        t.active = 1'b1;
        if (pick == 0) begin
            t.enabled = 1'($urandom_range(0, 1));
            t.active = t.enabled ? 1'b0 : 1'(($urandom_range(0, 1)));
        end
        t.layer = (pick <= 4) ? 8'd0 : 8'($urandom_range(1, 255));
        if (pick == 0) t.layer = 8'($urandom_range(0, 255));
        return t;
    endfunction

    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[4:0], m_tdata[12:5], m_tdata[20:13], m_tdata[28:21], m_tlast};
            if (pixels_due.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected pixel item: idx %0d rgb %h %h %h last %b",
                             got.idx, got.red, got.green, got.blue, got.last);
            end else begin
                want = pixels_due.pop_front();
                if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.last !== want.last)
                    note_mismatch(want, got);
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        tick_t t;
        logic [15:0] wval;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < PLAN_LEN; n++) begin
            if (plan[n].kind == ROW_WRITE) begin
                write_reg(plan[n].addr, plan[n].value[15:0]);
            end else begin
                t = '{plan[n].value, plan[n].layer, plan[n].en, plan[n].act};
                send_tick(t, plan[n].typed, plan[n].rgb);
                sender_gap();
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: wval = 16'd0;
                1: wval = 16'd127;
                2: wval = 16'd100;
                default: wval = 16'($urandom_range(0, 127));
            endcase
            // Junk in the unused upper bits must not reach the brightness.
            wval = (16'($urandom) & 16'hFF80) | wval;
            write_reg(lsc_pkg::REG_BRIGHTNESS, wval);
            case ($urandom_range(0, 5))
                0: wval = 16'd0;
                1: wval = 16'hFFFF;
                2: wval = 16'd1;
                default: wval = 16'($urandom_range(1, 65535));
            endcase
            write_reg(lsc_pkg::REG_PERIOD, wval);
            if (ph == NUM_PHASES - 1) calm <= 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_tick(random_tick(), 1'b0, 24'h000000);
                sender_gap();
            end
        end

        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (error_count == 0 && pixels_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
